[rtl/pls_pkg.sv]
// Shared constants, codes and types of the positional list block.
`timescale 1ns / 1ps

package pls_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int OP_W        = 3;
  localparam int POS_W       = 6;
  localparam int WEIGHT_W    = 8;
  localparam int PAYLOAD_W   = 24;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 6;
  localparam int TOTAL_W     = 13;
  localparam int MAXENT_W    = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [MAXENT_W-1:0] MAX_ENTRIES_RST  = 6'd32;
  localparam logic [TOTAL_W-1:0]  WEIGHT_LIMIT_RST = 13'd8160;

  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
  localparam logic [OP_W-1:0] OP_REPLACE  = 3'd2;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_WEIGHT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LIMIT = 2'd1;

  typedef struct packed {
    logic [WEIGHT_W-1:0]  weight;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

endpackage

[rtl/pls_if.sv]
// Request, response and configuration channels of the positional list block.
`timescale 1ns / 1ps

interface pls_req_if;
  logic                            valid;
  logic                            ready;
  logic [pls_pkg::OP_W-1:0]        op;
  logic [pls_pkg::POS_W-1:0]       position;
  logic [pls_pkg::WEIGHT_W-1:0]    entry_weight;
  logic [pls_pkg::PAYLOAD_W-1:0]   entry_payload;

  modport source (output valid, op, position, entry_weight, entry_payload, input ready);
  modport sink   (input valid, op, position, entry_weight, entry_payload, output ready);
endinterface

interface pls_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [pls_pkg::STATUS_W-1:0]      status;
  logic [pls_pkg::WEIGHT_W-1:0]      out_weight;
  logic [pls_pkg::PAYLOAD_W-1:0]     out_payload;
  logic [pls_pkg::COUNT_OUT_W-1:0]   entry_count;
  logic [pls_pkg::TOTAL_W-1:0]       weight_total;

  modport source (output valid, status, out_weight, out_payload, entry_count, weight_total,
                  input ready);
  modport sink   (input valid, status, out_weight, out_payload, entry_count, weight_total,
                  output ready);
endinterface

interface pls_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pls_pkg::CFG_IDX_W-1:0]     index;
  logic [pls_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/positional_list_with_weight_budget.sv]
// Top level of the positional list: control FSM, entry memory and config registers.
`timescale 1ns / 1ps

// Ordered list of up to min(max_entries, CAPACITY) entries (8-bit weight, 24-bit payload)
// kept in one single-port-write, registered-read memory, with a running weight total.
// One item is worked at a time. An op refused at decode, clear, or unknown op gives its
// result from the decode state; retrieve and replace first read the entry. Insert and delete
// move every entry behind the position one slot per cycle through the memory (read one
// address, write the neighbor next cycle). A result waiting in the output register does
// not hold off the next item; only emitting the following result waits for it to be
// taken. Config registers are written at any time, always ready.
module positional_list_with_weight_budget #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  pls_req_if.sink   req,
  pls_rsp_if.source rsp,
  pls_cfg_if.sink   cfg
);
  import pls_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW + 1 > POS_W + 1) ? CW + 1 : POS_W + 1;
  localparam int SUMW = TOTAL_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UP,
    S_PUT,
    S_DGET,
    S_DOWN,
    S_DFIN,
    S_READ
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]        count, count_next;
  logic [TOTAL_W-1:0]   wsum, wsum_next;
  logic [MAXENT_W-1:0]  max_entries;
  logic [TOTAL_W-1:0]   weight_limit;

  logic [OP_W-1:0]      op_q;
  logic [POS_W-1:0]     pos_q;
  logic [WEIGHT_W-1:0]  wgt_q;
  logic [PAYLOAD_W-1:0] pay_q;
  entry_t               del_q;
  logic [AW-1:0]        widx, widx_next;

  logic                   o_valid;
  logic [STATUS_W-1:0]    o_status;
  logic [WEIGHT_W-1:0]    o_weight;
  logic [PAYLOAD_W-1:0]   o_payload;
  logic [COUNT_OUT_W-1:0] o_count;
  logic [TOTAL_W-1:0]     o_total;

  logic                 emit;
  logic [STATUS_W-1:0]  e_status;
  logic [WEIGHT_W-1:0]  e_weight;
  logic [PAYLOAD_W-1:0] e_payload;
  logic [CMPW-1:0]      cnt_next_c;

  entry_t        mem [CAPACITY];
  entry_t        rdata;
  entry_t        wdata;
  logic          ren, we;
  logic [AW-1:0] raddr, waddr;
  logic [CMPW-1:0] addr_c;

  logic [CMPW-1:0] cnt_c, pos_c, pos_m1, widx_c, k_c;
  logic [AW-1:0]   k;
  logic            pos_ok, pos_ok_ins, is_full, can_emit;
  logic [SUMW-1:0] sum_ins, sum_rep, lim;

  assign cnt_c      = CMPW'(count);
  assign pos_c      = CMPW'(pos_q);
  assign pos_m1     = pos_c - CMPW'(1);
  assign k          = pos_m1[AW-1:0];
  assign k_c        = CMPW'(k);
  assign widx_c     = CMPW'(widx);
  assign pos_ok     = (pos_q != '0) && (pos_c <= cnt_c);
  assign pos_ok_ins = (pos_q != '0) && (pos_c <= cnt_c + CMPW'(1));
  assign is_full    = (cnt_c >= CMPW'(max_entries)) || (cnt_c >= CMPW'(CAPACITY));
  assign lim        = SUMW'(weight_limit);
  assign sum_ins    = SUMW'(wsum) + SUMW'(wgt_q);
  // total always includes the stored weight, so this never goes below zero
  assign sum_rep    = SUMW'(wsum) - SUMW'(rdata.weight) + SUMW'(wgt_q);
  assign can_emit   = !o_valid || rsp.ready;
  assign wdata      = (state == S_UP || state == S_DOWN) ? rdata : {wgt_q, pay_q};

  always_comb begin
    state_next = state;
    count_next = count;
    wsum_next  = wsum;
    widx_next  = widx;
    emit       = 1'b0;
    e_status   = ST_OK;
    e_weight   = '0;
    e_payload  = '0;
    ren        = 1'b0;
    we         = 1'b0;
    addr_c     = k_c;
    waddr      = k;

    unique case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (op_q) inside
          OP_INSERT: begin
            if (!pos_ok_ins) begin
              emit     = 1'b1;
              e_status = ST_BAD_POS;
            end else if (is_full) begin
              emit     = 1'b1;
              e_status = ST_FULL;
            end else if (sum_ins > lim) begin
              emit     = 1'b1;
              e_status = ST_WEIGHT;
            end else if (pos_c <= cnt_c) begin
              // open a hole: move entries up starting from the last one
              ren        = 1'b1;
              addr_c     = cnt_c - CMPW'(1);
              widx_next  = cnt_c[AW-1:0];
              state_next = S_UP;
            end else begin
              state_next = S_PUT;
            end
          end
          OP_DELETE: begin
            if (!pos_ok) begin
              emit     = 1'b1;
              e_status = ST_BAD_POS;
            end else begin
              ren        = 1'b1;
              state_next = S_DGET;
            end
          end
          OP_REPLACE, OP_RETRIEVE: begin
            if (!pos_ok) begin
              emit     = 1'b1;
              e_status = ST_BAD_POS;
            end else begin
              ren        = 1'b1;
              state_next = S_READ;
            end
          end
          OP_CLEAR: begin
            emit       = 1'b1;
            count_next = '0;
            wsum_next  = '0;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      S_UP: begin
        we    = 1'b1;
        waddr = widx;
        if (widx_c > k_c + CMPW'(1)) begin
          ren       = 1'b1;
          addr_c    = widx_c - CMPW'(2);
          widx_next = widx - 1'b1;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        emit       = 1'b1;
        we         = 1'b1;
        count_next = count + 1'b1;
        wsum_next  = sum_ins[TOTAL_W-1:0];
      end
      S_DGET: begin
        if (k_c + CMPW'(1) < cnt_c) begin
          ren        = 1'b1;
          addr_c     = k_c + CMPW'(1);
          widx_next  = k;
          state_next = S_DOWN;
        end else begin
          state_next = S_DFIN;
        end
      end
      S_DOWN: begin
        we    = 1'b1;
        waddr = widx;
        if (widx_c + CMPW'(2) < cnt_c) begin
          ren       = 1'b1;
          addr_c    = widx_c + CMPW'(2);
          widx_next = widx + 1'b1;
        end else begin
          state_next = S_DFIN;
        end
      end
      S_DFIN: begin
        emit       = 1'b1;
        e_weight   = del_q.weight;
        e_payload  = del_q.payload;
        count_next = count - 1'b1;
        wsum_next  = wsum - TOTAL_W'(del_q.weight);
      end
      S_READ: begin
        emit = 1'b1;
        if (op_q == OP_RETRIEVE) begin
          e_weight  = rdata.weight;
          e_payload = rdata.payload;
        end else if (sum_rep > lim) begin
          e_status = ST_WEIGHT;
        end else begin
          we        = 1'b1;
          wsum_next = sum_rep[TOTAL_W-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // finishing an item waits until the output register is free
    if (emit) begin
      if (can_emit) begin
        state_next = S_IDLE;
      end else begin
        emit       = 1'b0;
        we         = 1'b0;
        state_next = state;
        count_next = count;
        wsum_next  = wsum;
      end
    end

    raddr      = addr_c[AW-1:0];
    cnt_next_c = CMPW'(count_next);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (ren) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      wsum         <= '0;
      o_valid      <= 1'b0;
      max_entries  <= MAX_ENTRIES_RST;
      weight_limit <= WEIGHT_LIMIT_RST;
    end else begin
      state <= state_next;
      count <= count_next;
      wsum  <= wsum_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MAX_ENTRIES:  max_entries  <= cfg.data[MAXENT_W-1:0];
          REG_WEIGHT_LIMIT: weight_limit <= cfg.data[TOTAL_W-1:0];
          default: ;
        endcase
      end
    end
    if (state == S_IDLE && req.valid) begin
      op_q  <= req.op;
      pos_q <= req.position;
      wgt_q <= req.entry_weight;
      pay_q <= req.entry_payload;
    end
    if (state == S_DGET) del_q <= rdata;
    widx <= widx_next;
    if (emit) begin
      o_status  <= e_status;
      o_weight  <= e_weight;
      o_payload <= e_payload;
      o_count   <= cnt_next_c[COUNT_OUT_W-1:0];
      o_total   <= wsum_next;
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = o_valid;
  assign rsp.status       = o_status;
  assign rsp.out_weight   = o_weight;
  assign rsp.out_payload  = o_payload;
  assign rsp.entry_count  = o_count;
  assign rsp.weight_total = o_total;

`ifndef SYNTHESIS
  a_reject_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (emit && e_status != ST_OK) |=> (count == $past(count) && wsum == $past(wsum)))
    else $error("rejected item changed list state");

  a_shift_above_hole: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP) |-> (widx_c > k_c && widx_c < cnt_c + CMPW'(1)))
    else $error("insert shift writes outside the moved range");

  // insert and replace commit only when the new total fits the limit
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (emit && we) |-> (wsum_next <= weight_limit && CMPW'(count_next) <= CMPW'(CAPACITY)))
    else $error("committed write leaves total or count out of range");
`endif

endmodule

[tb/sv/positional_list_with_weight_budget_tb.sv]
// Self-checking testbench for the positional list with weight budget.
`timescale 1ns / 1ps

module positional_list_with_weight_budget_tb;
  import pls_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 56;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_CLEAR + 3'd1;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [WEIGHT_W-1:0]    weight;
    logic [PAYLOAD_W-1:0]   payload;
    logic [COUNT_OUT_W-1:0] count;
    logic [TOTAL_W-1:0]     total;
  } list_result_t;

  // Shadow copy of the list; works out the response of each accepted item.
  class weight_budget_list;
    logic [WEIGHT_W-1:0]  weights [CAPACITY_DEF];
    logic [PAYLOAD_W-1:0] payloads [CAPACITY_DEF];
    int unsigned          count;
    int unsigned          total;
    logic [MAXENT_W-1:0]  max_entries;
    logic [TOTAL_W-1:0]   weight_limit;
    list_result_t         pending_rsp[$];
    int unsigned          errors;

    function new();
      count        = 0;
      total        = 0;
      max_entries  = MAX_ENTRIES_RST;
      weight_limit = WEIGHT_LIMIT_RST;
      errors       = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MAX_ENTRIES) begin
        max_entries = data[MAXENT_W-1:0];
      end else if (idx == REG_WEIGHT_LIMIT) begin
        weight_limit = data[TOTAL_W-1:0];
      end
    endfunction

    function void accept_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [WEIGHT_W-1:0] w, logic [PAYLOAD_W-1:0] pay);
      list_result_t r;
      int unsigned  cap;
      int unsigned  k;
      int unsigned  sum;
      r   = '0;
      cap = (max_entries > CAPACITY_DEF) ? CAPACITY_DEF : max_entries;
      k   = (pos == 0) ? 0 : pos - 1;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          sum = total + w;
          if (pos < 1 || pos > count + 1) begin
            r.status = ST_BAD_POS;
          end else if (count >= cap) begin
            r.status = ST_FULL;
          end else if (sum > weight_limit) begin
            r.status = ST_WEIGHT;
          end else begin
            for (int i = count; i > k; i--) begin
              weights[i]  = weights[i-1];
              payloads[i] = payloads[i-1];
            end
            weights[k]  = w;
            payloads[k] = pay;
            count++;
            total = sum;
          end
        end
        OP_DELETE: begin
          if (pos < 1 || pos > count) begin
            r.status = ST_BAD_POS;
          end else begin
            r.weight  = weights[k];
            r.payload = payloads[k];
            for (int i = k; i + 1 < count; i++) begin
              weights[i]  = weights[i+1];
              payloads[i] = payloads[i+1];
            end
            count--;
            total = (total >= r.weight) ? total - r.weight : 0;
          end
        end
        OP_REPLACE: begin
          if (pos < 1 || pos > count) begin
            r.status = ST_BAD_POS;
          end else begin
            sum = total - weights[k] + w;
            if (sum > weight_limit) begin
              r.status = ST_WEIGHT;
            end else begin
              weights[k]  = w;
              payloads[k] = pay;
              total = sum;
            end
          end
        end
        OP_RETRIEVE: begin
          if (pos < 1 || pos > count) begin
            r.status = ST_BAD_POS;
          end else begin
            r.weight  = weights[k];
            r.payload = payloads[k];
          end
        end
        OP_CLEAR: begin
          count = 0;
          total = 0;
        end
        default: ;
      endcase
      r.count = count[COUNT_OUT_W-1:0];
      r.total = total[TOTAL_W-1:0];
      pending_rsp.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(list_result_t got);
      list_result_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with nothing outstanding, expected none, actual %0h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_weight", 32'(want.weight), 32'(got.weight));
      compare_field("out_payload", 32'(want.payload), 32'(got.payload));
      compare_field("entry_count", 32'(want.count), 32'(got.count));
      compare_field("weight_total", 32'(want.total), 32'(got.total));
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int unsigned idle_cycles;
  weight_budget_list list = new();

  pls_req_if req_ch();
  pls_rsp_if rsp_ch();
  pls_cfg_if cfg_ch();

  positional_list_with_weight_budget dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Response side: random back-pressure, none while quiet.
  initial begin
    int unsigned stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 20) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      list.check_response({rsp_ch.status, rsp_ch.out_weight, rsp_ch.out_payload,
                           rsp_ch.entry_count, rsp_ch.weight_total});
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [WEIGHT_W-1:0] w, input logic [PAYLOAD_W-1:0] pay);
    int unsigned gap;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.position      <= pos;
    req_ch.entry_weight  <= w;
    req_ch.entry_payload <= pay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    list.accept_request(op, pos, w, pay);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (list.pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    list.set_register(idx, data);
    @(negedge clk);
  endtask

  // Only between phases, with nothing in flight.
  task automatic apply_settings(input int unsigned max_ent, input int unsigned limit);
    drain();
    write_reg(REG_MAX_ENTRIES, CFG_DATA_W'(max_ent));
    write_reg(REG_WEIGHT_LIMIT, CFG_DATA_W'(limit));
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_item();
    logic [OP_W-1:0]      op;
    logic [POS_W-1:0]     pos;
    logic [WEIGHT_W-1:0]  w;
    int unsigned          r;
    int unsigned          top;
    r = $urandom_range(0, 99);
    if (r < 40)      op = OP_INSERT;
    else if (r < 60) op = OP_DELETE;
    else if (r < 75) op = OP_REPLACE;
    else if (r < 90) op = OP_RETRIEVE;
    else if (r < 92) op = OP_CLEAR;
    else if (r < 95) op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else             op = OP_W'($urandom_range(0, OP_UNUSED_HI));
    top = (op == OP_INSERT) ? list.count + 1 : list.count;
    if (top != 0 && $urandom_range(0, 99) < 80) pos = POS_W'($urandom_range(1, top));
    else pos = POS_W'($urandom_range(0, 63));
    r = $urandom_range(0, 9);
    if (r == 0)      w = '0;
    else if (r == 1) w = '1;
    else             w = WEIGHT_W'($urandom);
    send_item(op, pos, w, PAYLOAD_W'($urandom));
  endtask

  initial begin
    int unsigned max_set [PHASES];
    int unsigned lim_set [PHASES];
    max_set              = '{32, 63, 7, 1, 32, 0, 20, 32};
    lim_set              = '{8160, 8191, 1500, 255, 0, 8160, 900, 8160};
    rst                  = 1'b1;
    quiet                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.op            = OP_INSERT;
    req_ch.position      = '0;
    req_ch.entry_weight  = '0;
    req_ch.entry_payload = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_MAX_ENTRIES;
    cfg_ch.data          = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty list, bounds, ordering, extremes, unused ops, clear.
    apply_settings(32, 8160);
    send_item(OP_RETRIEVE, 1, 0, 0);
    send_item(OP_DELETE, 0, 0, 0);
    send_item(OP_INSERT, 2, 8'h11, 24'h111111);
    send_item(OP_INSERT, 0, 8'h11, 24'h111111);
    send_item(OP_INSERT, 1, 8'hFF, 24'hFFFFFF);
    send_item(OP_INSERT, 1, 8'h00, 24'h000000);
    send_item(OP_INSERT, 3, 8'h5A, 24'hA5A5A5);
    send_item(OP_INSERT, 2, 8'hA5, 24'h5A5A5A);
    send_item(OP_RETRIEVE, 1, 0, 0);
    send_item(OP_RETRIEVE, 2, 0, 0);
    send_item(OP_RETRIEVE, 4, 0, 0);
    send_item(OP_RETRIEVE, 63, 0, 0);
    send_item(OP_REPLACE, 2, 8'hFF, 24'h123456);
    send_item(OP_REPLACE, 5, 8'h01, 24'h000001);
    send_item(OP_DELETE, 4, 0, 0);
    send_item(OP_DELETE, 1, 0, 0);
    for (int o = OP_UNUSED_LO; o <= OP_UNUSED_HI; o++) begin
      send_item(OP_W'(o), 1, 8'h33, 24'h333333);
    end
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_RETRIEVE, 1, 0, 0);

    // Full list and weight refusals at a tiny capacity.
    apply_settings(2, 300);
    send_item(OP_INSERT, 1, 8'd200, 24'h0000AA);
    send_item(OP_INSERT, 1, 8'd200, 24'h0000BB);
    send_item(OP_INSERT, 1, 8'd100, 24'h0000CC);
    send_item(OP_INSERT, 3, 8'd0, 24'h0000DD);
    // Limit lowered below the current sum: refusals, then delete still works.
    apply_settings(2, 50);
    send_item(OP_REPLACE, 1, 8'd0, 24'h0000EE);
    send_item(OP_DELETE, 1, 0, 0);
    apply_settings(0, 8191);
    send_item(OP_INSERT, 1, 8'd1, 24'h0000FF);

    for (int p = 0; p < PHASES; p++) begin
      apply_settings(max_set[p], lim_set[p]);
      quiet = (p % 2 == 1);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (p == 2 && i == PHASE_LEN / 2) drain();
        random_item();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (list.errors == 0 && list.pending_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
